>>> rtl/ncl_pkg.sv
// ncl_pkg: shared constants and types for the nearest candidate list core
// no dependencies
package ncl_pkg;
  localparam int MAX_CITIES_DEF = 256;
  localparam int CANDIDATES_DEF = 32;
  localparam int COORD_BITS_DEF = 20;
  localparam int ID_W = 8;
  localparam int RANK_W = 5;
  localparam int NCFG_W = 9;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDQ,
    ST_GETQ,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } bk_state_t;
endpackage

>>> rtl/ncl_ram.sv
// ncl_ram: generic single write port, single read port ram with registered read
// no dependencies
module ncl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/ncl_front.sv
// ncl_front: accepts transactions, writes loads into coordinate store, queues queries
// depends on ncl_pkg
module ncl_front #(
  parameter int MAX_CITIES = 256,
  parameter int COORD_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_func,
  input  logic [ncl_pkg::ID_W-1:0]      in_city_id,
  input  logic signed [COORD_BITS-1:0]  in_coord_x,
  input  logic signed [COORD_BITS-1:0]  in_coord_y,
  output logic                          st_we,
  output logic [$clog2(MAX_CITIES)-1:0] st_waddr,
  output logic [2*COORD_BITS-1:0]       st_wdata,
  output logic                          q_valid,
  output logic [ncl_pkg::ID_W-1:0]      q_id,
  input  logic                          q_take,
  input  logic                          bk_busy
);
  import ncl_pkg::*;
  localparam int AW = $clog2(MAX_CITIES);
  // two-entry query queue
  logic [ID_W-1:0] qd_r [2];
  logic [ID_W-1:0] qd_nxt [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic acc, is_q, in_rng;

  // a load waits while a query is queued or the back end is busy, so the scan sees a steady store
  assign in_full = (cnt_r == 2'd2) || (!is_q && (cnt_r != 2'd0 || bk_busy));
  assign acc = in_push && !in_full;
  assign is_q = (func_t'(in_func) == FUNC_QUERY);
  assign in_rng = ({24'd0, in_city_id} < 32'(MAX_CITIES));
  assign st_we = acc && !is_q && in_rng;
  assign st_waddr = AW'(in_city_id);
  assign st_wdata = {in_coord_x, in_coord_y};
  assign q_valid = (cnt_r != 2'd0);
  assign q_id = qd_r[0];

  always_comb begin
    qd_nxt = qd_r;
    cnt_nxt = cnt_r;
    if (q_take && q_valid) begin
      qd_nxt[0] = qd_r[1];
      cnt_nxt = cnt_nxt - 2'd1;
    end
    if (acc && is_q) begin
      qd_nxt[cnt_nxt[0]] = in_city_id;
      cnt_nxt = cnt_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    qd_r <= qd_nxt;
  end
endmodule

>>> rtl/ncl_back.sv
// ncl_back: scans cities per query, keeps sorted candidate list, emits results
// depends on ncl_pkg
module ncl_back #(
  parameter int MAX_CITIES = 256,
  parameter int CANDIDATES = 32,
  parameter int COORD_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ncl_pkg::NCFG_W-1:0]    num_cities,
  input  logic                          q_valid,
  input  logic [ncl_pkg::ID_W-1:0]      q_id,
  output logic                          q_take,
  output logic                          bk_busy,
  output logic [$clog2(MAX_CITIES)-1:0] st_raddr,
  input  logic [2*COORD_BITS-1:0]       st_rdata,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [ncl_pkg::ID_W-1:0]      out_neighbor_id,
  output logic [ncl_pkg::RANK_W-1:0]    out_rank,
  output logic                          out_found,
  output logic                          out_last
);
  import ncl_pkg::*;
  localparam int AW = $clog2(MAX_CITIES);
  localparam int CW = AW + 1;
  localparam int DW = 2 * COORD_BITS + 1;
  localparam int KW = (CANDIDATES > 1) ? $clog2(CANDIDATES) : 1;

  bk_state_t st_r, st_nxt;
  logic [ID_W-1:0] qid_r;
  logic signed [COORD_BITS-1:0] qx_r, qy_r;
  logic [CW-1:0] j_r, n_r;
  logic [CW-1:0] sj_r;
  logic          sv_r;
  logic [KW-1:0] k_r;
  logic [KW:0]   kc_r;
  // candidate list (sorted)
  logic [DW-1:0] ld_r [CANDIDATES];
  logic [AW-1:0] li_r [CANDIDATES];
  logic          lv_r [CANDIDATES];
  // distance pipeline
  logic signed [COORD_BITS:0] dx_r, dy_r;
  logic [2*COORD_BITS+1:0] sx_r, sy_r;
  logic p1v_r, p2v_r;
  logic [AW-1:0] p1i_r, p2i_r;
  logic [DW-1:0] dsum;
  logic out_v_r;
  logic [ID_W-1:0] o_id_r;
  logic [RANK_W-1:0] o_rk_r;
  logic o_f_r, o_l_r;
  logic [CW-1:0] nclamp;
  logic emit;

  assign nclamp = (32'(num_cities) > 32'(MAX_CITIES)) ? CW'(MAX_CITIES) : CW'(num_cities);
  assign dsum = DW'(sx_r) + DW'(sy_r);
  assign emit = (st_r == ST_EMIT) && (!out_v_r || out_pop) &&
                (kc_r != (KW+1)'(CANDIDATES));

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (q_valid) st_nxt = ST_RDQ;
      ST_RDQ:   st_nxt = ST_GETQ;
      ST_GETQ:  st_nxt = ST_SCAN;
      ST_SCAN:  if (j_r == n_r) st_nxt = ST_DRAIN;
      ST_DRAIN: if (!sv_r && !p1v_r && !p2v_r) st_nxt = ST_EMIT;
      ST_EMIT:  if (!out_v_r || out_pop) begin
        if (kc_r == (KW+1)'(CANDIDATES)) st_nxt = ST_IDLE;
      end
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // query coordinates are addressed at the take and again in ST_RDQ; ST_GETQ captures them
  always_comb begin
    q_take = (st_r == ST_IDLE) && q_valid;
    bk_busy = (st_r != ST_IDLE);
    case (st_r)
      ST_IDLE: st_raddr = AW'(q_id);
      ST_RDQ:  st_raddr = AW'(qid_r);
      default: st_raddr = AW'(j_r);
    endcase
  end

  assign out_empty = !out_v_r;
  assign out_neighbor_id = o_id_r;
  assign out_rank = o_rk_r;
  assign out_found = o_f_r;
  assign out_last = o_l_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      out_v_r <= 1'b0;
      sv_r <= 1'b0;
      p1v_r <= 1'b0;
      p2v_r <= 1'b0;
      for (int c = 0; c < CANDIDATES; c++) lv_r[c] <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (emit) out_v_r <= 1'b1;
      else if (out_pop && out_v_r) out_v_r <= 1'b0;
      // stage 0: address issued, data next cycle
      sv_r <= (st_r == ST_SCAN) && (j_r != n_r);
      sj_r <= j_r;
      // stage 1: differences
      p1v_r <= sv_r && (sj_r != CW'(qid_r));
      p1i_r <= AW'(sj_r);
      dx_r <= (COORD_BITS+1)'(qx_r) - (COORD_BITS+1)'($signed(st_rdata[2*COORD_BITS-1:COORD_BITS]));
      dy_r <= (COORD_BITS+1)'(qy_r) - (COORD_BITS+1)'($signed(st_rdata[COORD_BITS-1:0]));
      // stage 2: squares
      p2v_r <= p1v_r;
      p2i_r <= p1i_r;
      sx_r <= (2*COORD_BITS+2)'(dx_r * dx_r);
      sy_r <= (2*COORD_BITS+2)'(dy_r * dy_r);
      case (st_r)
        ST_IDLE: if (q_valid) begin
          qid_r <= q_id;
          n_r <= nclamp;
          j_r <= '0;
          k_r <= '0;
          kc_r <= '0;
          for (int c = 0; c < CANDIDATES; c++) lv_r[c] <= 1'b0;
        end
        ST_GETQ: begin
          qx_r <= $signed(st_rdata[2*COORD_BITS-1:COORD_BITS]);
          qy_r <= $signed(st_rdata[COORD_BITS-1:0]);
          // query out of range scans nothing
          if (CW'(qid_r) >= n_r) n_r <= '0;
        end
        ST_SCAN: if (j_r != n_r) j_r <= j_r + CW'(1);
        ST_EMIT: if (emit) begin
          o_id_r <= lv_r[k_r] ? ID_W'(li_r[k_r]) : '0;
          o_f_r <= lv_r[k_r];
          o_rk_r <= RANK_W'(kc_r);
          o_l_r <= (kc_r == (KW+1)'(CANDIDATES - 1));
          k_r <= k_r + KW'(1);
          kc_r <= kc_r + (KW+1)'(1);
        end
        default: ;
      endcase
      // sorted insert: index rises in scan order, so ties keep the earlier one
      if (p2v_r) begin
        for (int c = CANDIDATES - 1; c >= 0; c--) begin
          if (!lv_r[c] || dsum < ld_r[c]) begin
            if (c == 0 || (lv_r[c-1] && !(dsum < ld_r[c-1]))) begin
              lv_r[c] <= 1'b1;
              ld_r[c] <= dsum;
              li_r[c] <= p2i_r;
            end else begin
              lv_r[c] <= lv_r[c-1];
              ld_r[c] <= ld_r[c-1];
              li_r[c] <= li_r[c-1];
            end
          end
        end
      end
    end
  end
endmodule

>>> rtl/nearest_candidate_list_core.sv
// nearest_candidate_list_core: k nearest neighbor candidate list, top level
// a load transaction waits while a query is queued or in work; a query scans
// the cities with one coordinate ram read per city, then delivers CANDIDATES
// results; one query in work at a time, a two-entry queue decouples intake
// from the scan; reset is synchronous active low, clears control and sets
// num_cities to 256; coordinates undefined
module nearest_candidate_list_core #(
  parameter int MAX_CITIES = ncl_pkg::MAX_CITIES_DEF,
  parameter int CANDIDATES = ncl_pkg::CANDIDATES_DEF,
  parameter int COORD_BITS = ncl_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [ncl_pkg::NCFG_W-1:0]   cfg_wdata,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic                         in_func,
  input  logic [ncl_pkg::ID_W-1:0]     in_city_id,
  input  logic signed [COORD_BITS-1:0] in_coord_x,
  input  logic signed [COORD_BITS-1:0] in_coord_y,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [ncl_pkg::ID_W-1:0]     out_neighbor_id,
  output logic [ncl_pkg::RANK_W-1:0]   out_rank,
  output logic                         out_found,
  output logic                         out_last
);
  import ncl_pkg::*;
  localparam int AW = $clog2(MAX_CITIES);

  // num_cities register
  logic [NCFG_W-1:0] ncity_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncity_r <= NCFG_W'(256);
    end else if (cfg_we) begin
      ncity_r <= cfg_wdata;
    end
  end

  logic                    st_we;
  logic [AW-1:0]           st_waddr, st_raddr;
  logic [2*COORD_BITS-1:0] st_wdata, st_rdata;
  logic                    q_valid, q_take;
  logic [ID_W-1:0]         q_id;
  logic                    bk_busy;

  // front: intake and classification of transactions
  ncl_front #(.MAX_CITIES(MAX_CITIES), .COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_func, .in_city_id, .in_coord_x,
    .in_coord_y, .st_we, .st_waddr, .st_wdata, .q_valid, .q_id, .q_take,
    .bk_busy
  );

  // coordinate store, x and y packed in one word
  ncl_ram #(.WIDTH(2*COORD_BITS), .DEPTH(MAX_CITIES)) u_store (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  // back: scan, sorted insertion and result delivery
  ncl_back #(.MAX_CITIES(MAX_CITIES), .CANDIDATES(CANDIDATES),
             .COORD_BITS(COORD_BITS)) u_back (
    .clk, .rst_n, .num_cities(ncity_r), .q_valid, .q_id, .q_take, .bk_busy,
    .st_raddr, .st_rdata, .out_empty, .out_pop, .out_neighbor_id,
    .out_rank, .out_found, .out_last
  );
endmodule

>>> tb/tb_top.sv
// tb_top: self-checking testbench for nearest_candidate_list_core
// depends on rtl/ncl_pkg.sv and rtl/nearest_candidate_list_core.sv
`timescale 1ns / 1ps

import ncl_pkg::*;

typedef struct {
  logic [ID_W-1:0]   neighbor;
  logic [RANK_W-1:0] rank;
  logic              found;
  logic              last;
} cand_t;

class cand_scoreboard;
  logic signed [COORD_BITS_DEF-1:0] x_mem[MAX_CITIES_DEF];
  logic signed [COORD_BITS_DEF-1:0] y_mem[MAX_CITIES_DEF];
  int    cities_used;
  cand_t cand_q[$];
  int    errors;
  int    checked;
  int    queries;

  function new();
    cities_used = 256;
    errors = 0;
    checked = 0;
    queries = 0;
    for (int i = 0; i < MAX_CITIES_DEF; i++) begin
      x_mem[i] = '0;
      y_mem[i] = '0;
    end
  endfunction

  function void set_cities(int v);
    cities_used = (v > MAX_CITIES_DEF) ? MAX_CITIES_DEF : v;
  endfunction

  function longint unsigned dist_sq(int a, int b);
    longint dx;
    longint dy;
    dx = longint'(x_mem[a]) - longint'(x_mem[b]);
    dy = longint'(y_mem[a]) - longint'(y_mem[b]);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return longint'(dx * dx + dy * dy);
  endfunction

  // accepted input transaction: store a load, or build the ranked list
  function void note_item(func_t f, logic [ID_W-1:0] id,
                          logic signed [COORD_BITS_DEF-1:0] x,
                          logic signed [COORD_BITS_DEF-1:0] y);
    bit taken[MAX_CITIES_DEF];
    bit got;
    bit dry;
    int best;
    longint unsigned best_d;
    longint unsigned d;
    cand_t c;
    if (f == FUNC_LOAD) begin
      x_mem[id] = x;
      y_mem[id] = y;
      return;
    end
    queries++;
    foreach (taken[i]) taken[i] = 0;
    dry = (id >= cities_used);
    for (int k = 0; k < CANDIDATES_DEF; k++) begin
      got = 0;
      best = 0;
      best_d = 0;
      if (!dry) begin
        for (int j = 0; j < cities_used; j++) begin
          if (j == id || taken[j]) continue;
          d = dist_sq(id, j);
          if (!got || d < best_d) begin
            got = 1;
            best_d = d;
            best = j;
          end
        end
        if (got) taken[best] = 1;
        else dry = 1;
      end
      c.neighbor = got ? best[ID_W-1:0] : '0;
      c.rank = k[RANK_W-1:0];
      c.found = got;
      c.last = (k == CANDIDATES_DEF - 1);
      cand_q.push_back(c);
    end
  endfunction

  function void check_result(logic [ID_W-1:0] nb, logic [RANK_W-1:0] rk,
                             logic fd, logic lst);
    cand_t e;
    checked++;
    if (cand_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result: id %0d rank %0d", nb, rk);
      return;
    end
    e = cand_q.pop_front();
    if (nb !== e.neighbor || rk !== e.rank || fd !== e.found || lst !== e.last) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp id %0d rank %0d found %0d last %0d, got %0d %0d %0d %0d",
                 e.neighbor, e.rank, e.found, e.last, nb, rk, fd, lst);
    end
  endfunction

  function int pending();
    return cand_q.size();
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE = 400;   // worst scan plus delivery of one query

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [NCFG_W-1:0]           cfg_wdata;
  logic                        in_push;
  logic                        in_full;
  logic                        in_func;
  logic [ID_W-1:0]             in_city_id;
  logic signed [COORD_BITS_DEF-1:0] in_coord_x;
  logic signed [COORD_BITS_DEF-1:0] in_coord_y;
  logic                        out_empty;
  logic                        out_pop;
  logic [ID_W-1:0]             out_neighbor_id;
  logic [RANK_W-1:0]           out_rank;
  logic                        out_found;
  logic                        out_last;

  cand_scoreboard sb;
  bit quiet;          // when set neither side idles
  bit loaded[MAX_CITIES_DEF];
  int cycles;

  nearest_candidate_list_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_push(in_push), .in_full(in_full), .in_func(in_func),
    .in_city_id(in_city_id), .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_neighbor_id(out_neighbor_id), .out_rank(out_rank),
    .out_found(out_found), .out_last(out_last)
  );

  initial clk = 0;
  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("nearest_candidate_list_core verification failed");
      $finish;
    end
  end

  // result side: check each popped result, then pick the next pop
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      sb.check_result(out_neighbor_id, out_rank, out_found, out_last);
    if (!rst_n) out_pop <= 1'b0;
    else out_pop <= quiet || ($urandom_range(99) >= 13);
  end

  // coordinates: full range, extremes, or a small grid that forces ties
  function automatic logic signed [COORD_BITS_DEF-1:0] pick_coord();
    case ($urandom_range(3))
      0: return COORD_BITS_DEF'($urandom);
      1: case ($urandom_range(2))
           0: return -20'sd524288;
           1: return 20'sd524287;
           default: return '0;
         endcase
      default: return COORD_BITS_DEF'(($signed($urandom_range(4)) - 2) * 16);
    endcase
  endfunction

  // one input transaction; call from a rising edge step
  task automatic send_item(func_t f, logic [ID_W-1:0] id,
                           logic signed [COORD_BITS_DEF-1:0] x,
                           logic signed [COORD_BITS_DEF-1:0] y);
    while (!quiet && $urandom_range(99) < 13) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_func <= f;
    in_city_id <= id;
    in_coord_x <= x;
    in_coord_y <= y;
    do @(posedge clk); while (in_full);
    sb.note_item(f, id, x, y);
    if (f == FUNC_LOAD) loaded[id] = 1;
  endtask

  task automatic load_city(int id);
    send_item(FUNC_LOAD, id[ID_W-1:0], pick_coord(), pick_coord());
  endtask

  task automatic query_city(int id);
    send_item(FUNC_QUERY, id[ID_W-1:0], pick_coord(), pick_coord());
  endtask

  // stop sending and let every outstanding query finish
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cities(int v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v[NCFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_cities(v);
  endtask

  // every city in use must hold coordinates before a query scans it
  task automatic fill_unloaded(int n);
    int lim;
    lim = (n > MAX_CITIES_DEF) ? MAX_CITIES_DEF : n;
    for (int i = 0; i < lim; i++)
      if (!loaded[i]) load_city(i);
  endtask

  int settings[6] = '{24, 8, 64, 2, 40, 48};
  int n_eff;

  initial begin
    sb = new();
    foreach (loaded[i]) loaded[i] = 0;
    quiet = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = '0;
    in_push = 0;
    in_func = FUNC_LOAD;
    in_city_id = '0;
    in_coord_x = '0;
    in_coord_y = '0;
    out_pop = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: two cities at opposite corners, out of range query, small registers
    write_cities(2);
    send_item(FUNC_LOAD, 8'd0, -20'sd524288, -20'sd524288);
    send_item(FUNC_LOAD, 8'd1, 20'sd524287, 20'sd524287);
    send_item(FUNC_QUERY, 8'd0, '0, '0);
    send_item(FUNC_QUERY, 8'd1, '0, '0);
    send_item(FUNC_LOAD, 8'd255, 20'sd524287, -20'sd524288);   // stored past num_cities
    send_item(FUNC_QUERY, 8'd255, '0, '0);                      // out of range
    write_cities(0);
    query_city(0);
    write_cities(1);
    query_city(0);
    // a cluster of equal distances decides order by index
    write_cities(6);
    for (int i = 2; i < 6; i++) send_item(FUNC_LOAD, i[7:0], 20'sd16, 20'sd16);
    send_item(FUNC_LOAD, 8'd0, '0, '0);
    send_item(FUNC_LOAD, 8'd1, 20'sd32, '0);
    query_city(0);
    query_city(3);
    query_city(5);

    // random phases over several register settings
    foreach (settings[p]) begin
      write_cities(settings[p]);
      n_eff = (settings[p] > MAX_CITIES_DEF) ? MAX_CITIES_DEF : settings[p];
      quiet = (p == 2);
      fill_unloaded(n_eff);
      for (int k = 0; k < 15; k++) begin
        if (p == 4 && k == 13) drain();   // sender holds off until all results are in
        if ($urandom_range(99) < 55) begin
          if ($urandom_range(9) == 0) query_city($urandom_range(255));
          else query_city($urandom_range(n_eff - 1));
        end else begin
          load_city($urandom_range(255));
        end
      end
      quiet = 0;
    end

    drain();
    $display("ran %0d queries, checked %0d results over city counts 0 to 64",
             sb.queries, sb.checked);
    $display("mismatches: %0d, results still expected: %0d", sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("nearest_candidate_list_core verification clean");
    end else begin
      $display("nearest_candidate_list_core verification failed");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/ncl_pkg.sv
rtl/ncl_ram.sv
rtl/ncl_front.sv
rtl/ncl_back.sv
rtl/nearest_candidate_list_core.sv
tb/tb_top.sv
